[src/udc_pkg.sv]
// shared types and constants of the utf-8 decode and classify block
package udc_pkg;

    // codepoint width
    localparam int CP_W = 21;

    // default depth of the queue between decoder and classifier
    localparam int QUEUE_DEPTH_DEF = 2;

    // per-byte result status
    typedef enum logic [1:0] {
        ST_PENDING  = 2'd0,
        ST_COMPLETE = 2'd1,
        ST_INVALID  = 2'd2
    } t_status;

    // decoded item handed from the decoder to the classifier
    typedef struct packed {
        t_status          status;
        logic [CP_W-1:0]  code_point;
    } t_queue_item;

endpackage

[src/udc_if.sv]
// handshake interfaces for the byte input and the result output

interface udc_byte_if ();
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);
endinterface

interface udc_result_if import udc_pkg::*; ();
    logic            valid;
    logic            ready;
    t_status         status;
    logic [CP_W-1:0] code_point;
    logic            is_letter;
    logic            is_space;

    modport source (
        output valid, output status, output code_point,
        output is_letter, output is_space, input ready
    );
    modport sink (
        input valid, input status, input code_point,
        input is_letter, input is_space, output ready
    );
endinterface

[src/udc_front.sv]
// byte decoder: accumulator and pending count, one byte per cycle while the queue has room
module udc_front import udc_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    udc_byte_if.sink      i_byte,
    input  logic          i_queue_ready,
    output logic          o_push,
    output t_queue_item   o_item
);

    logic [CP_W-1:0] r_acc;
    logic [CP_W-1:0] n_acc;
    logic [1:0]      r_pend;
    logic [1:0]      n_pend;
    logic [CP_W-1:0] shifted;
    logic [7:0]      b;

    assign b              = i_byte.data_byte;
    assign i_byte.ready   = i_queue_ready;
    assign o_push         = i_byte.valid && i_queue_ready;
    assign shifted        = {r_acc[CP_W-7:0], b[5:0]};

    always_comb begin
        n_acc             = r_acc;
        n_pend            = r_pend;
        o_item.status     = ST_INVALID;
        o_item.code_point = '0;
        unique casez (b)
            8'b0???????: begin
                // ascii completes as itself, accumulator kept
                n_pend            = 2'd0;
                o_item.status     = ST_COMPLETE;
                o_item.code_point = CP_W'(b[6:0]);
            end
            8'b110?????: begin
                n_acc         = CP_W'(b[4:0]);
                n_pend        = 2'd1;
                o_item.status = ST_PENDING;
            end
            8'b1110????: begin
                n_acc         = CP_W'(b[3:0]);
                n_pend        = 2'd2;
                o_item.status = ST_PENDING;
            end
            8'b11110???: begin
                n_acc         = CP_W'(b[2:0]);
                n_pend        = 2'd3;
                o_item.status = ST_PENDING;
            end
            8'b10??????: begin
                // stray continuation stays invalid with state untouched
                if (r_pend != 2'd0) begin
                    n_acc  = shifted;
                    n_pend = r_pend - 2'd1;
                    if (r_pend == 2'd1) begin
                        o_item.status     = ST_COMPLETE;
                        o_item.code_point = shifted;
                    end else begin
                        o_item.status = ST_PENDING;
                    end
                end
            end
            default: begin
                // 0xf8..0xff: invalid, state untouched
                o_item.status = ST_INVALID;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_pend <= 2'd0;
        end else if (o_push) begin
            r_acc  <= n_acc;
            r_pend <= n_pend;
        end
    end

endmodule

[src/udc_queue.sv]
// short fifo between decoder and classifier
module udc_queue import udc_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  t_queue_item  i_item,
    output logic         o_ready,
    input  logic         i_pop,
    output logic         o_valid,
    output t_queue_item  o_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_queue_item      r_slot [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;

    assign o_ready = (r_cnt != CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_slot[r_rd];

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= ptr_inc(r_wr);
            end
            if (i_pop) begin
                r_rd <= ptr_inc(r_rd);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> o_ready)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("queue pop while empty");
`endif

endmodule

[src/udc_back.sv]
// classifier and output register
module udc_back import udc_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  t_queue_item   i_item,
    output logic          o_pop,
    udc_result_if.source  o_res
);

    localparam logic [CP_W-1:0] CJK_LO    = CP_W'('h4E00);
    localparam logic [CP_W-1:0] CJK_HI    = CP_W'('h9FFF);
    localparam logic [CP_W-1:0] LETLIK_LO = CP_W'('h2100);
    localparam logic [CP_W-1:0] LETLIK_HI = CP_W'('h214F);
    localparam logic [CP_W-1:0] NNBSP     = CP_W'('h202F);
    localparam logic [CP_W-1:0] WJ        = CP_W'('h2060);
    localparam logic [CP_W-1:0] FIGSP     = CP_W'('h2007);

    function automatic logic in_rng(input logic [CP_W-1:0] v,
                                    input logic [CP_W-1:0] lo,
                                    input logic [CP_W-1:0] hi);
        in_rng = (v >= lo) && (v <= hi);
    endfunction

    function automatic logic letter_test(input logic [CP_W-1:0] cp);
        letter_test = in_rng(cp, CP_W'('h41), CP_W'('h5A))
                   || in_rng(cp, CP_W'('h61), CP_W'('h7A))
                   || in_rng(cp, CP_W'('hC0), CP_W'('h2AF))
                   || in_rng(cp, CP_W'('h370), CP_W'('h52F))
                   || in_rng(cp, LETLIK_LO, LETLIK_HI)
                   || in_rng(cp, CJK_LO, CJK_HI);
    endfunction

    function automatic logic space_test(input logic [CP_W-1:0] cp);
        space_test = in_rng(cp, CP_W'('h09), CP_W'('h0D))
                  || (cp == CP_W'('h20)) || (cp == CP_W'('hA0))
                  || (cp == FIGSP) || (cp == NNBSP) || (cp == WJ);
    endfunction

    logic            r_valid;
    t_status         r_status;
    logic [CP_W-1:0] r_cp;
    logic            r_letter;
    logic            r_space;
    logic            done;

    assign o_pop = i_valid && (!r_valid || o_res.ready);
    assign done  = (i_item.status == ST_COMPLETE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_status <= i_item.status;
            r_cp     <= i_item.code_point;
            r_letter <= done && letter_test(i_item.code_point);
            r_space  <= done && space_test(i_item.code_point);
        end
    end

    assign o_res.valid      = r_valid;
    assign o_res.status     = r_status;
    assign o_res.code_point = r_cp;
    assign o_res.is_letter  = r_letter;
    assign o_res.is_space   = r_space;

`ifndef SYNTH
    a_flags_only_complete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && (r_status != ST_COMPLETE)) |->
            ((r_cp == '0) && !r_letter && !r_space))
        else $error("payload set on non-complete result");

    a_letter_space_disjoint: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> !(r_letter && r_space))
        else $error("codepoint flagged as letter and space");
`endif

endmodule

[src/utf8_decode_classify_core.sv]
// top level of the utf-8 decode and classify block
//
// byte-serial utf-8 decoder: every accepted byte gives exactly one result item
// with a status (pending, complete or invalid), the codepoint when complete,
// and letter and space flags for complete codepoints. the decoder takes one
// byte per clock while the fifo has room; that rate is set by the update of
// the accumulator and pending count in the decoder for each accepted byte.
// an accepted byte is written into the fifo, then moved into the result
// register of the classifier when that register is free, and shown from there.
// a short fifo (QUEUE_DEPTH items) sits between the decoder and the
// classifier so a stalled result port does not back up the decoder at once;
// input ready drops only when that fifo is full. no overlong or surrogate
// checks are made; a new lead byte drops an unfinished sequence, and bytes
// 0xf8..0xff or a stray continuation report invalid without touching state
module utf8_decode_classify_core import udc_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    udc_byte_if.sink      i_byte,
    udc_result_if.source  o_res
);

    // decoder to queue
    logic        push;
    logic        queue_ready;
    t_queue_item push_item;

    // queue to classifier
    logic        head_valid;
    logic        pop;
    t_queue_item head_item;

    // front: decodes each byte and keeps the sequence state
    udc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_byte        (i_byte),
        .i_queue_ready (queue_ready),
        .o_push        (push),
        .o_item        (push_item)
    );

    // decoupling fifo
    udc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .o_ready (queue_ready),
        .i_pop   (pop),
        .o_valid (head_valid),
        .o_item  (head_item)
    );

    // back: classifies complete codepoints and holds the result register
    udc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (head_valid),
        .i_item  (head_item),
        .o_pop   (pop),
        .o_res   (o_res)
    );

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// self-checking testbench for utf8_decode_classify_core with random byte streams
module tb_top import udc_pkg::*; ();

    localparam int CLK_HALF_NS     = 5;
    localparam int RESET_CYCLES    = 4;
    localparam int RES_HOLD_CYCLES = 300;   // long result-port hold-off
    localparam int SETTLE_CYCLES   = 20;    // end-of-run wait for stray items
    localparam int RANDOM_BYTES    = 1250;
    localparam int STALL_CPS       = 40;
    localparam int PAUSE_ROUNDS    = 6;
    localparam int MAX_REPORTS     = 10;

    // one result item as the block should report it
    typedef struct packed {
        t_status         status;
        logic [CP_W-1:0] code_point;
        logic            is_letter;
        logic            is_space;
    } t_byte_result;

    logic i_clk;
    logic i_rst_n;

    udc_byte_if   byte_if ();
    udc_result_if res_if ();

    utf8_decode_classify_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (byte_if),
        .o_res   (res_if)
    );

    // decoder state as the block should hold it
    logic [CP_W-1:0] model_acc;
    logic [1:0]      model_left;

    // expected result items, oldest first
    t_byte_result expected_decodes [$];

    // idling controls shared between the tests and the two sides
    logic sender_idle_en;
    logic recv_idle_en;
    logic res_hold_req;

    int n_bytes_sent;
    int n_results_seen;
    int n_complete;
    int n_letter;
    int n_space;
    int n_invalid;
    int n_pending;
    int n_holds;
    int n_errors;

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF_NS i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    function automatic logic cp_is_letter(input logic [CP_W-1:0] cp);
        return (cp >= 'h41 && cp <= 'h5A) || (cp >= 'h61 && cp <= 'h7A) ||
               (cp >= 'hC0 && cp <= 'h2AF) || (cp >= 'h370 && cp <= 'h52F) ||
               (cp >= 'h2100 && cp <= 'h214F) || (cp >= 'h4E00 && cp <= 'h9FFF);
    endfunction

    function automatic logic cp_is_space(input logic [CP_W-1:0] cp);
        return (cp >= 'h09 && cp <= 'h0D) || cp == 'h20 || cp == 'hA0 ||
               cp == 'h2007 || cp == 'h202F || cp == 'h2060;
    endfunction

    // advances the decoder state by one byte and gives the result item
    function automatic t_byte_result predict_decode(input logic [7:0] b);
        t_byte_result r;
        r.status     = ST_INVALID;
        r.code_point = '0;
        r.is_letter  = 1'b0;
        r.is_space   = 1'b0;
        if (b <= 8'h7F) begin
            // ascii completes as itself, accumulator untouched
            r.status     = ST_COMPLETE;
            r.code_point = CP_W'(b);
            model_left   = 2'd0;
        end else if (b[7:5] == 3'b110) begin
            model_acc  = CP_W'(b[4:0]);
            model_left = 2'd1;
            r.status   = ST_PENDING;
        end else if (b[7:4] == 4'b1110) begin
            model_acc  = CP_W'(b[3:0]);
            model_left = 2'd2;
            r.status   = ST_PENDING;
        end else if (b[7:3] == 5'b11110) begin
            model_acc  = CP_W'(b[2:0]);
            model_left = 2'd3;
            r.status   = ST_PENDING;
        end else if (b[7:6] == 2'b10 && model_left != 2'd0) begin
            model_acc  = {model_acc[CP_W-7:0], b[5:0]};
            model_left = model_left - 2'd1;
            if (model_left == 2'd0) begin
                r.status     = ST_COMPLETE;
                r.code_point = model_acc;
            end else begin
                r.status = ST_PENDING;
            end
        end
        // stray continuation and 0xf8..0xff fall through as invalid, state kept
        if (r.status == ST_COMPLETE) begin
            r.is_letter = cp_is_letter(r.code_point);
            r.is_space  = cp_is_space(r.code_point);
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // idling and reporting helpers
    // ------------------------------------------------------------------

    // mostly back to back, sometimes short gaps, now and then a long one
    function automatic int pick_gap(input logic en);
        int r;
        if (!en)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void note_failure(input string msg);
        n_errors++;
        if (n_errors <= MAX_REPORTS)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endfunction

    // ------------------------------------------------------------------
    // byte sender: called at a rising edge, returns at the accepting edge
    // ------------------------------------------------------------------

    task automatic send_byte(input logic [7:0] b);
        int   gap;
        logic took;
        gap = pick_gap(sender_idle_en);
        // valid is only dropped when a gap follows, never toggled within a step
        if (gap > 0) begin
            byte_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        byte_if.valid     <= 1'b1;
        byte_if.data_byte <= b;
        // ready is settled by the falling edge; it holds until the next rising edge
        do begin
            @(negedge i_clk);
            took = byte_if.ready;
            @(posedge i_clk);
        end while (!took);
        expected_decodes.push_back(predict_decode(b));
        n_bytes_sent++;
    endtask

    task automatic sender_rest();
        byte_if.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (expected_decodes.size() != 0)
            @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // stimulus building blocks
    // ------------------------------------------------------------------

    function automatic int min_len(input logic [CP_W-1:0] cp);
        if (cp < 'h80)
            return 1;
        if (cp < 'h800)
            return 2;
        if (cp < 'h10000)
            return 3;
        return 4;
    endfunction

    function automatic logic [7:0] lead_byte(input logic [CP_W-1:0] cp, input int len);
        case (len)
            1:       return {1'b0, cp[6:0]};
            2:       return {3'b110, cp[10:6]};
            3:       return {4'b1110, cp[15:12]};
            default: return {5'b11110, cp[20:18]};
        endcase
    endfunction

    // continuation carrying payload bits [6*idx +: 6]
    function automatic logic [7:0] cont_byte(input logic [CP_W-1:0] cp, input int idx);
        return {2'b10, cp[6*idx +: 6]};
    endfunction

    // biased toward the edges of the letter ranges and the listed spaces
    function automatic logic [CP_W-1:0] pick_codepoint();
        logic [CP_W-1:0] range_marks [24];
        logic [CP_W-1:0] space_marks [12];
        int r;
        range_marks = '{'h40, 'h41, 'h5A, 'h5B, 'h60, 'h61, 'h7A, 'h7B,
                        'hBF, 'hC0, 'h2AF, 'h2B0, 'h36F, 'h370, 'h52F, 'h530,
                        'h20FF, 'h2100, 'h214F, 'h2150, 'h4DFF, 'h4E00, 'h9FFF, 'hA000};
        space_marks = '{'h08, 'h09, 'h0D, 'h0E, 'h1F, 'h20, 'h21, 'hA0,
                        'h2006, 'h2007, 'h202F, 'h2060};
        r = $urandom_range(0, 9);
        case (r)
            0, 1:    return CP_W'($urandom_range(0, 'h7F));
            2:       return range_marks[$urandom_range(0, 23)];
            3:       return space_marks[$urandom_range(0, 11)];
            4:       return CP_W'($urandom_range('hC0, 'h52F));
            5:       return CP_W'($urandom_range('h2100, 'h214F));
            6:       return CP_W'($urandom_range('h4E00, 'h9FFF));
            7:       return CP_W'($urandom_range('h80, 'h7FF));
            8:       return CP_W'($urandom_range('h800, 'hFFFF));
            default: return CP_W'($urandom_range('h10000, 'h1FFFFF));
        endcase
    endfunction

    // well-formed sequence, sometimes overlong since the block does not check for it
    task automatic send_codepoint(input logic [CP_W-1:0] cp);
        int len;
        len = min_len(cp);
        if (len < 4 && $urandom_range(0, 9) == 0)
            len = len + 1;
        send_byte(lead_byte(cp, len));
        for (int i = len - 2; i >= 0; i--)
            send_byte(cont_byte(cp, i));
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    task automatic test_directed();
        logic [7:0] stream [26];
        // ascii extremes, stray continuations, 0xf8 and 0xff, the longest
        // sequence at full payload, 3-byte letter and space, 0xff in the middle
        // of a sequence, a lead byte abandoning one, ascii interrupting one
        stream = '{8'h00, 8'h7F, 8'h80, 8'hFF, 8'hF8,
                   8'hE4, 8'hB8, 8'h80,
                   8'hE2, 8'h80, 8'hAF,
                   8'hF7, 8'hBF, 8'hBF, 8'hBF,
                   8'hE2, 8'h80, 8'hFF, 8'h80,
                   8'hC3, 8'hE2, 8'h81, 8'hA0,
                   8'hE2, 8'h41, 8'h80};
        sender_idle_en = 1'b0;
        recv_idle_en   = 1'b0;
        foreach (stream[i])
            send_byte(stream[i]);
        sender_rest();
        wait_drained();
    endtask

    task automatic test_random_stream();
        int               stop_at;
        int               kind;
        int               len;
        int               cut;
        logic [CP_W-1:0]  cp;
        logic [7:0]       junk;
        stop_at = n_bytes_sent + RANDOM_BYTES;
        while (n_bytes_sent < stop_at) begin
            // change the idling mix now and then, including stretches without gaps
            if ($urandom_range(0, 15) == 0) begin
                sender_idle_en = ($urandom_range(0, 3) != 0);
                recv_idle_en   = ($urandom_range(0, 3) != 0);
            end
            kind = $urandom_range(0, 99);
            cp   = pick_codepoint();
            len  = $urandom_range(2, 4);
            if (kind < 70) begin
                send_codepoint(cp);
            end else if (kind < 80) begin
                // truncated sequence, next item abandons or breaks it
                send_byte(lead_byte(cp, len));
                cut = $urandom_range(0, len - 2);
                for (int i = len - 2; i >= len - 1 - cut; i--)
                    send_byte(cont_byte(cp, i));
            end else if (kind < 90) begin
                // something foreign dropped into the middle of a sequence
                case ($urandom_range(0, 3))
                    0:       junk = 8'hF8 | 8'($urandom_range(0, 7));
                    1:       junk = 8'($urandom_range(0, 'h7F));
                    2:       junk = 8'hC0 | 8'($urandom_range(0, 'h3F));
                    default: junk = 8'($urandom_range(0, 255));
                endcase
                cut = $urandom_range(0, len - 2);
                send_byte(lead_byte(cp, len));
                for (int i = len - 2; i >= 0; i--) begin
                    if (i == cut)
                        send_byte(junk);
                    send_byte(cont_byte(cp, i));
                end
            end else if (kind < 96) begin
                send_byte(8'($urandom_range(0, 255)));
            end else begin
                // run of continuations, stray unless an earlier item left a sequence pending
                repeat ($urandom_range(1, 3))
                    send_byte(8'h80 | 8'($urandom_range(0, 'h3F)));
            end
        end
        sender_rest();
        wait_drained();
    endtask

    // result port held off while the sender keeps offering, to fill the block
    task automatic test_result_stall();
        sender_idle_en = 1'b0;
        recv_idle_en   = 1'b1;
        res_hold_req   = 1'b1;
        repeat (STALL_CPS)
            send_codepoint(pick_codepoint());
        sender_rest();
        wait_drained();
    endtask

    // short bursts, each followed by a full drain before the next
    task automatic test_drain_pause();
        sender_idle_en = 1'b1;
        recv_idle_en   = 1'b1;
        repeat (PAUSE_ROUNDS) begin
            repeat ($urandom_range(8, 16))
                send_codepoint(pick_codepoint());
            sender_rest();
            wait_drained();
        end
    endtask

    // ------------------------------------------------------------------
    // result receiver: drives ready with gaps and the long hold-off
    // ------------------------------------------------------------------

    initial begin
        int gap_left;
        gap_left = 0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (res_hold_req) begin
                res_if.ready <= 1'b0;
                repeat (RES_HOLD_CYCLES) @(posedge i_clk);
                res_hold_req = 1'b0;
                n_holds++;
            end else if (gap_left > 0) begin
                res_if.ready <= 1'b0;
                gap_left--;
            end else begin
                res_if.ready <= 1'b1;
                gap_left = pick_gap(recv_idle_en);
            end
        end
    end

    // ------------------------------------------------------------------
    // result checker: valid and ready are stable at the falling edge, so an
    // item seen there is the one taken at the next rising edge
    // ------------------------------------------------------------------

    initial begin
        t_byte_result want;
        forever begin
            @(negedge i_clk);
            if (i_rst_n === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
                n_results_seen++;
                if (expected_decodes.size() == 0) begin
                    note_failure($sformatf("result with nothing expected: status %0d cp %06h",
                                           res_if.status, res_if.code_point));
                end else begin
                    want = expected_decodes.pop_front();
                    case (want.status)
                        ST_COMPLETE: n_complete++;
                        ST_INVALID:  n_invalid++;
                        default:     n_pending++;
                    endcase
                    n_letter += want.is_letter;
                    n_space  += want.is_space;
                    if (res_if.status !== want.status ||
                        res_if.code_point !== want.code_point ||
                        res_if.is_letter !== want.is_letter ||
                        res_if.is_space !== want.is_space)
                        note_failure($sformatf(
                            {"expected status %0d cp %06h letter %0b space %0b, ",
                             "got status %0d cp %06h letter %0b space %0b"},
                            want.status, want.code_point, want.is_letter, want.is_space,
                            res_if.status, res_if.code_point, res_if.is_letter,
                            res_if.is_space));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------

    initial begin
        i_rst_n           <= 1'b0;
        byte_if.valid     <= 1'b0;
        byte_if.data_byte <= 8'h00;
        sender_idle_en = 1'b1;
        recv_idle_en   = 1'b1;
        res_hold_req   = 1'b0;
        model_acc      = '0;
        model_left     = 2'd0;
        n_bytes_sent   = 0;
        n_results_seen = 0;
        n_complete     = 0;
        n_letter       = 0;
        n_space        = 0;
        n_invalid      = 0;
        n_pending      = 0;
        n_holds        = 0;
        n_errors       = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_stream();
        test_result_stall();
        test_drain_pause();

        // catch any stray item after the last expected one
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display({"covered %0d bytes, %0d results: %0d complete (%0d letters, ",
                  "%0d spaces), %0d invalid, %0d pending"},
                 n_bytes_sent, n_results_seen, n_complete, n_letter, n_space, n_invalid,
                 n_pending);
        $display("result port held off %0d time(s) for %0d cycles under load; %0d mismatches",
                 n_holds, RES_HOLD_CYCLES, n_errors);
        if (n_errors == 0)
            $display("utf8_decode_classify_core regression: pass");
        else
            $display("utf8_decode_classify_core regression: fail");
        $finish;
    end

    // hard stop, far beyond the slowest legal run
    initial begin
        #10_000_000;
        $display("utf8_decode_classify_core regression: fail");
        $finish;
    end

endmodule
